/* src/atb_pkg.sv */
// atb_pkg: shared types of the alias table builder
// controller states, datapath command and status structs; no dependencies
`default_nettype none

package atb_pkg;

    typedef enum logic [4:0] {
        S_LOAD,
        S_ZCHK,
        S_SC_RD,
        S_SC_MUL,
        S_SC_DIV,
        S_SC_WR,
        S_PAIR,
        S_LO_RD,
        S_LO_IDX,
        S_LO_W,
        S_HI_RD,
        S_HI_IDX,
        S_HI_W,
        S_STEP,
        S_LEFT,
        S_LL_RD,
        S_LL_WR,
        S_LS_RD,
        S_LS_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT,
        S_ERR_WAIT
    } atb_state_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic sc_start;
        logic sc_mul;
        logic div_step;
        logic sc_write;
        logic pair_init;
        logic lo_fetch;
        logic lo_latch;
        logic hi_fetch;
        logic hi_latch;
        logic pair_step;
        logic ll_write;
        logic ls_write;
        logic out_init;
        logic out_load;
        logic out_next;
        logic err_load;
    } atb_cmd_t;

    typedef struct packed {
        logic sum_zero;
        logic sc_last;
        logic div_done;
        logic can_pair;
        logic need_lo;
        logic need_hi;
        logic large_left;
        logic small_left;
        logic out_last;
    } atb_status_t;

endpackage

`default_nettype wire

/* src/atb_ram.sv */
// atb_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module atb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/atb_ctrl.sv */
// atb_ctrl: sequencer of the alias table builder
// depends on atb_pkg (state enum, command and status structs)
`default_nettype none

module atb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last_weight,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire atb_pkg::atb_status_t status,
    output atb_pkg::atb_cmd_t        cmd
);

    import atb_pkg::*;

    atb_state_t state_reg;
    atb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:     if (in_valid && last_weight) state_next = S_ZCHK;
            S_ZCHK:     state_next = status.sum_zero ? S_ERR_WAIT : S_SC_RD;
            S_SC_RD:    state_next = S_SC_MUL;
            S_SC_MUL:   state_next = S_SC_DIV;
            S_SC_DIV:   if (status.div_done) state_next = S_SC_WR;
            S_SC_WR:    state_next = status.sc_last ? S_PAIR : S_SC_RD;
            S_PAIR:
            begin
                if (!status.can_pair)
                begin
                    state_next = S_LEFT;
                end
                else if (status.need_lo)
                begin
                    state_next = S_LO_RD;
                end
                else if (status.need_hi)
                begin
                    state_next = S_HI_RD;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_LO_RD:    state_next = S_LO_IDX;
            S_LO_IDX:   state_next = S_LO_W;
            S_LO_W:     state_next = S_PAIR;
            S_HI_RD:    state_next = S_HI_IDX;
            S_HI_IDX:   state_next = S_HI_W;
            S_HI_W:     state_next = S_PAIR;
            S_STEP:     state_next = S_PAIR;
            S_LEFT:
            begin
                if (status.large_left)
                begin
                    state_next = S_LL_RD;
                end
                else if (status.small_left)
                begin
                    state_next = S_LS_RD;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end
            S_LL_RD:    state_next = S_LL_WR;
            S_LL_WR:    state_next = S_LEFT;
            S_LS_RD:    state_next = S_LS_WR;
            S_LS_WR:    state_next = S_LEFT;
            S_OUT_RD:   state_next = S_OUT_LD;
            S_OUT_LD:   state_next = S_OUT_WAIT;
            S_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            S_ERR_WAIT: if (out_ready) state_next = S_LOAD;
            default:    state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_ZCHK:
            begin
                cmd.err_load = status.sum_zero;
                cmd.sc_start = !status.sum_zero;
            end
            S_SC_MUL:   cmd.sc_mul = 1'b1;
            S_SC_DIV:   cmd.div_step = 1'b1;
            S_SC_WR:
            begin
                cmd.sc_write  = 1'b1;
                cmd.pair_init = status.sc_last;
            end
            S_LO_IDX:   cmd.lo_fetch = 1'b1;
            S_LO_W:     cmd.lo_latch = 1'b1;
            S_HI_IDX:   cmd.hi_fetch = 1'b1;
            S_HI_W:     cmd.hi_latch = 1'b1;
            S_STEP:     cmd.pair_step = 1'b1;
            S_LEFT:     cmd.out_init = !status.large_left && !status.small_left;
            S_LL_WR:    cmd.ll_write = 1'b1;
            S_LS_WR:    cmd.ls_write = 1'b1;
            S_OUT_LD:   cmd.out_load = 1'b1;
            S_OUT_WAIT:
            begin
                out_valid    = 1'b1;
                cmd.clr      = out_ready && status.out_last;
                cmd.out_next = out_ready && !status.out_last;
            end
            S_ERR_WAIT:
            begin
                out_valid = 1'b1;
                cmd.clr   = out_ready;
            end
            default:    cmd = '0;
        endcase
    end

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output side active together");

    a_last_builds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_weight) |=> (state_reg == S_ZCHK))
        else $error("last weight did not start a build");

    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZCHK && status.sum_zero) |=> (state_reg == S_ERR_WAIT))
        else $error("zero sum did not give an error transaction");
`endif

endmodule

`default_nettype wire

/* src/atb_datapath.sv */
// atb_datapath: weight store, scaling divider, pairing lists and table memory
// depends on atb_pkg (command and status structs) and atb_ram
`default_nettype none

module atb_datapath #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [31:0]                        weight,
    input  wire atb_pkg::atb_cmd_t                  cmd,
    output atb_pkg::atb_status_t                    status,
    output logic      [$clog2(MAX_ENTRIES)-1:0]     entry_index,
    output logic      [FRACTION_BITS:0]             probability,
    output logic      [$clog2(MAX_ENTRIES)-1:0]     alias_index,
    output logic                                    has_alias,
    output logic                                    zero_sum_error,
    output logic                                    last_entry
);

    import atb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = 32 + IDX_W;
    localparam int PROD_W = 32 + CNT_W;
    localparam int Q_W    = CNT_W + FRACTION_BITS;
    localparam int DCNT_W = $clog2(Q_W);
    localparam int PROB_W = FRACTION_BITS + 1;
    localparam int ENT_W  = PROB_W + 1 + IDX_W;
    localparam logic [Q_W-1:0]    ONE     = Q_W'(1) << FRACTION_BITS;
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [DCNT_W-1:0] DIV_END = DCNT_W'(Q_W - 1);

    // control registers
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  small_len_reg, small_len_next;
    logic [CNT_W-1:0]  nl_reg, nl_next;
    logic [CNT_W-1:0]  ps_reg, ps_next;
    logic [CNT_W-1:0]  kl_reg, kl_next;
    logic              need_lo_reg, need_lo_next;
    logic              need_hi_reg, need_hi_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    // payload registers
    logic [SUM_W-1:0]  rem_reg;
    logic [Q_W-1:0]    low_reg;
    logic [IDX_W-1:0]  lo_idx_reg, hi_idx_reg;
    logic [Q_W-1:0]    lo_w_reg, hi_w_reg;
    logic [IDX_W-1:0]  entry_index_reg, alias_index_reg;
    logic [PROB_W-1:0] probability_reg;
    logic              has_alias_reg, zero_sum_error_reg, last_entry_reg;

    // memory ports
    logic [31:0]       w_rdata;
    logic [Q_W-1:0]    scaled_rdata;
    logic [IDX_W-1:0]  small_rdata, large_rdata;
    logic [ENT_W-1:0]  ent_rdata;
    logic              w_we, small_we, large_we, ent_we;
    logic [IDX_W-1:0]  small_waddr, small_wdata, ent_waddr, scaled_raddr;
    logic [ENT_W-1:0]  ent_wdata;

    // arithmetic
    logic [PROD_W-1:0] prod;
    logic [SUM_W:0]    rem_shift, rem_diff;
    logic              div_ge;
    logic [Q_W:0]      pair_sum;
    logic [Q_W-1:0]    new_w;
    logic              new_small, is_small, room;

    assign room      = count_reg < MAX_CNT;
    assign prod      = PROD_W'(w_rdata) * PROD_W'(count_reg);
    assign rem_shift = {rem_reg, low_reg[Q_W-1]};
    assign rem_diff  = rem_shift - {1'b0, sum_reg};
    assign div_ge    = rem_shift >= {1'b0, sum_reg};
    assign pair_sum  = (Q_W+1)'(lo_w_reg) + (Q_W+1)'(hi_w_reg) - (Q_W+1)'(ONE);
    assign new_w     = pair_sum[Q_W-1:0];
    assign new_small = new_w < ONE;
    assign is_small  = low_reg < ONE;

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        small_len_next = small_len_reg;
        nl_next        = nl_reg;
        ps_next        = ps_reg;
        kl_next        = kl_reg;
        need_lo_next   = need_lo_reg;
        need_hi_next   = need_hi_reg;
        dcnt_next      = dcnt_reg;

        if (cmd.clr)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (cmd.load && room)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUM_W'(weight);
        end

        if (cmd.sc_start || cmd.out_init)
        begin
            idx_next = '0;
        end
        else if (cmd.sc_write || cmd.out_next)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.sc_start)
        begin
            small_len_next = '0;
            nl_next        = '0;
            ps_next        = '0;
            kl_next        = '0;
        end
        else if (cmd.sc_write)
        begin
            if (is_small)
            begin
                small_len_next = small_len_reg + 1'b1;
            end
            else
            begin
                nl_next = nl_reg + 1'b1;
            end
        end

        if (cmd.pair_init)
        begin
            ps_next      = '0;
            kl_next      = '0;
            need_lo_next = 1'b1;
            need_hi_next = 1'b1;
        end
        if (cmd.lo_latch)
        begin
            need_lo_next = 1'b0;
        end
        if (cmd.hi_latch)
        begin
            need_hi_next = 1'b0;
        end
        if (cmd.pair_step)
        begin
            // large entry drops below one: it becomes the next small entry
            if (new_small)
            begin
                need_hi_next = 1'b1;
                kl_next      = kl_reg + 1'b1;
            end
            else
            begin
                need_lo_next = 1'b1;
                ps_next      = ps_reg + 1'b1;
            end
        end
        if (cmd.ll_write)
        begin
            kl_next = kl_reg + 1'b1;
        end
        if (cmd.ls_write)
        begin
            ps_next = ps_reg + 1'b1;
        end

        if (cmd.sc_mul)
        begin
            dcnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_next = dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            small_len_reg <= '0;
            nl_reg        <= '0;
            ps_reg        <= '0;
            kl_reg        <= '0;
            need_lo_reg   <= 1'b0;
            need_hi_reg   <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            small_len_reg <= small_len_next;
            nl_reg        <= nl_next;
            ps_reg        <= ps_next;
            kl_reg        <= kl_next;
            need_lo_reg   <= need_lo_next;
            need_hi_reg   <= need_hi_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    // restoring divider: rem/low start as the shifted product, low ends as quotient
    always_ff @(posedge clk)
    begin
        if (cmd.sc_mul)
        begin
            rem_reg <= SUM_W'(prod[PROD_W-1:CNT_W]);
            low_reg <= {prod[CNT_W-1:0], {FRACTION_BITS{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], div_ge};
        end

        if (cmd.lo_fetch)
        begin
            lo_idx_reg <= small_rdata;
        end
        if (cmd.lo_latch)
        begin
            lo_w_reg <= scaled_rdata;
        end
        if (cmd.hi_fetch)
        begin
            hi_idx_reg <= large_rdata;
        end
        if (cmd.hi_latch)
        begin
            hi_w_reg <= scaled_rdata;
        end
        if (cmd.pair_step)
        begin
            if (new_small)
            begin
                lo_idx_reg <= hi_idx_reg;
                lo_w_reg   <= new_w;
            end
            else
            begin
                hi_w_reg <= new_w;
            end
        end

        if (cmd.out_load)
        begin
            entry_index_reg    <= idx_reg[IDX_W-1:0];
            probability_reg    <= ent_rdata[ENT_W-1 -: PROB_W];
            has_alias_reg      <= ent_rdata[IDX_W];
            alias_index_reg    <= ent_rdata[IDX_W-1:0];
            zero_sum_error_reg <= 1'b0;
            last_entry_reg     <= idx_reg == (count_reg - 1'b1);
        end
        else if (cmd.err_load)
        begin
            entry_index_reg    <= '0;
            probability_reg    <= '0;
            has_alias_reg      <= 1'b0;
            alias_index_reg    <= '0;
            zero_sum_error_reg <= 1'b1;
            last_entry_reg     <= 1'b1;
        end
    end

    assign w_we         = cmd.load && room;
    assign small_we     = (cmd.sc_write && is_small) || (cmd.pair_step && new_small);
    assign small_waddr  = cmd.sc_write ? small_len_reg[IDX_W-1:0] : ps_reg[IDX_W-1:0];
    assign small_wdata  = cmd.sc_write ? idx_reg[IDX_W-1:0] : hi_idx_reg;
    assign large_we     = cmd.sc_write && !is_small;
    assign scaled_raddr = cmd.hi_fetch ? large_rdata : small_rdata;
    assign ent_we       = cmd.pair_step || cmd.ll_write || cmd.ls_write;
    assign ent_waddr    = cmd.pair_step ? lo_idx_reg :
                          (cmd.ll_write ? large_rdata : small_rdata);
    assign ent_wdata    = cmd.pair_step ? {lo_w_reg[PROB_W-1:0], 1'b1, hi_idx_reg} :
                          {ONE[PROB_W-1:0], 1'b0, {IDX_W{1'b0}}};

    atb_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (weight),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (w_rdata)
    );

    atb_ram #(.WIDTH(Q_W), .DEPTH(MAX_ENTRIES)) u_scaled_ram (
        .clk   (clk),
        .we    (cmd.sc_write),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (low_reg),
        .raddr (scaled_raddr),
        .rdata (scaled_rdata)
    );

    atb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small_ram (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_waddr),
        .wdata (small_wdata),
        .raddr (ps_reg[IDX_W-1:0]),
        .rdata (small_rdata)
    );

    atb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large_ram (
        .clk   (clk),
        .we    (large_we),
        .waddr (nl_reg[IDX_W-1:0]),
        .wdata (idx_reg[IDX_W-1:0]),
        .raddr (kl_reg[IDX_W-1:0]),
        .rdata (large_rdata)
    );

    atb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ent_rdata)
    );

    assign status.sum_zero   = sum_reg == '0;
    assign status.sc_last    = idx_reg == (count_reg - 1'b1);
    assign status.div_done   = dcnt_reg == DIV_END;
    assign status.can_pair   = (ps_reg < small_len_reg) && (kl_reg < nl_reg);
    assign status.need_lo    = need_lo_reg;
    assign status.need_hi    = need_hi_reg;
    assign status.large_left = kl_reg < nl_reg;
    assign status.small_left = ps_reg < small_len_reg;
    assign status.out_last   = last_entry_reg;

    assign entry_index    = entry_index_reg;
    assign probability    = probability_reg;
    assign alias_index    = alias_index_reg;
    assign has_alias      = has_alias_reg;
    assign zero_sum_error = zero_sum_error_reg;
    assign last_entry     = last_entry_reg;

`ifndef SYNTH
    a_ps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ps_reg <= small_len_reg)
        else $error("small list pointer past its length");

    a_kl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kl_reg <= nl_reg)
        else $error("large list pointer past its length");

    a_lo_small: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pair_step |-> (lo_w_reg < ONE))
        else $error("paired low entry is not below one");
`endif

endmodule

`default_nettype wire

/* src/alias_table_builder_top.sv */
// alias_table_builder_top: top level of the alias table builder
// depends on atb_pkg, atb_ctrl, atb_datapath (which holds the atb_ram instances)
//
// usage
//   input channel: weight, last_weight with in_valid/in_ready. one weight per
//   transaction; in_ready is high only while the block is loading, so one
//   weight a cycle can be taken. weights past MAX_ENTRIES are dropped, but a
//   last mark on such a transaction still starts the build
//   output channel: one transaction per table entry in ascending entry order,
//   or a single transaction with zero_sum_error set when all stored weights were zero
//   work after the last weight
//     scaling: entries are scaled one by one, each by the
//     one-bit-per-cycle restoring divider
//     pairing: each pairing step and each leftover entry is paced by the
//     registered reads of the index lists and scaled weight memory
//   readout: each entry is read from the table memory and loaded for output
//   a stalled receiver simply holds the current output transaction; nothing
//   else moves until it is taken. no new weights are taken until the last
//   table transaction is delivered
//   reset clears the entry count and weight sum and returns to loading; the
//   memories need no clearing since every entry is written before it is read
`default_nettype none

module alias_table_builder_top #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [31:0]                    weight,
    input  wire logic                           last_weight,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    output logic      [$clog2(MAX_ENTRIES)-1:0] entry_index,
    output logic      [FRACTION_BITS:0]         probability,
    output logic      [$clog2(MAX_ENTRIES)-1:0] alias_index,
    output logic                                has_alias,
    output logic                                zero_sum_error,
    output logic                                last_entry,
    output logic                                out_valid,
    input  wire logic                           out_ready
);

    import atb_pkg::*;

    // command and status between sequencer and datapath
    atb_cmd_t    cmd;
    atb_status_t status;

    atb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_weight (last_weight),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd)
    );

    atb_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .weight         (weight),
        .cmd            (cmd),
        .status         (status),
        .entry_index    (entry_index),
        .probability    (probability),
        .alias_index    (alias_index),
        .has_alias      (has_alias),
        .zero_sum_error (zero_sum_error),
        .last_entry     (last_entry)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking testbench for alias_table_builder_top
// drives weight sets through a queue-fed driver, predicts the alias table per set
// and compares every output transaction; depends on the rtl in src
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N    = 64;
    localparam int FRAC     = 24;
    localparam longint ONE  = 64'd1 << FRAC;
    localparam int LIMIT    = 3000000;

    typedef struct {
        logic [31:0] w;
        logic        last;
    } weight_txn_t;

    typedef struct {
        logic [5:0]  idx;
        logic [24:0] prob;
        logic [5:0]  alias_idx;
        logic        has_alias;
        logic        zero_err;
        logic        last;
    } entry_txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [31:0] weight = '0;
    logic        last_weight = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [5:0]  entry_index;
    logic [24:0] probability;
    logic [5:0]  alias_index;
    logic        has_alias;
    logic        zero_sum_error;
    logic        last_entry;
    logic        out_valid;
    logic        out_ready = 1'b0;

    alias_table_builder_top #(.MAX_ENTRIES(MAX_N), .FRACTION_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .weight(weight), .last_weight(last_weight),
        .in_valid(in_valid), .in_ready(in_ready),
        .entry_index(entry_index), .probability(probability),
        .alias_index(alias_index), .has_alias(has_alias),
        .zero_sum_error(zero_sum_error), .last_entry(last_entry),
        .out_valid(out_valid), .out_ready(out_ready)
    );

    always #4 clk = ~clk;

    weight_txn_t pending_weights[$];
    entry_txn_t  expected_entries[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;     // no idling near the end of the run

    // predictor state: the weights of the set being loaded
    logic [31:0] set_weights[MAX_N];
    int          set_count = 0;
    longint unsigned set_sum = 0;

    // vose construction on the loaded set, pushes one transaction per entry
    task automatic build_alias_table();
        longint unsigned sw[MAX_N];
        int          order[MAX_N];
        logic [24:0] prob[MAX_N];
        logic [6:0]  alias_tag[MAX_N];
        longint unsigned num, q, r;
        int          n, nsmall, ps, pl, lo, hi;
        entry_txn_t  e;
        n = set_count;
        nsmall = 0;
        for (int i = 0; i < n; i++)
        begin
            num = longint'(set_weights[i]) * n;
            q = num / set_sum;
            r = num % set_sum;
            sw[i] = (q << FRAC) + ((r << FRAC) / set_sum);
        end
        // stable partition, small side first
        for (int i = 0; i < n; i++)
            if (sw[i] < ONE)
            begin
                order[nsmall] = i;
                nsmall++;
            end
        pl = nsmall;
        for (int i = 0; i < n; i++)
            if (sw[i] >= ONE)
            begin
                order[pl] = i;
                pl++;
            end
        ps = 0;
        pl = nsmall;
        while (ps < nsmall && pl < n)
        begin
            lo = order[ps];
            hi = order[pl];
            prob[lo] = sw[lo][24:0];
            alias_tag[lo] = {1'b1, hi[5:0]};
            sw[hi] = sw[lo] + sw[hi] - ONE;
            if (sw[hi] < ONE)
            begin
                order[ps] = hi;
                pl++;
            end
            else
                ps++;
        end
        for (; pl < n; pl++)
        begin
            prob[order[pl]] = ONE[24:0];
            alias_tag[order[pl]] = '0;
        end
        for (; ps < nsmall; ps++)
        begin
            prob[order[ps]] = ONE[24:0];
            alias_tag[order[ps]] = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            e.idx = i[5:0];
            e.prob = prob[i];
            e.alias_idx = alias_tag[i][5:0];
            e.has_alias = alias_tag[i][6];
            e.zero_err = 1'b0;
            e.last = (i == n - 1);
            expected_entries.push_back(e);
        end
    endtask

    // called for every accepted weight transaction
    task automatic predict_weight(input weight_txn_t t);
        entry_txn_t e;
        if (set_count < MAX_N)
        begin
            set_weights[set_count] = t.w;
            set_count++;
            set_sum += t.w;
        end
        if (t.last)
        begin
            if (set_sum == 0)
            begin
                e = '{idx: '0, prob: '0, alias_idx: '0, has_alias: 1'b0,
                      zero_err: 1'b1, last: 1'b1};
                expected_entries.push_back(e);
            end
            else
                build_alias_table();
            set_count = 0;
            set_sum = 0;
        end
    endtask

    task automatic queue_weight(input logic [31:0] w, input logic last);
        weight_txn_t t;
        t.w = w;
        t.last = last;
        pending_weights.push_back(t);
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 15);
            3: return $urandom & 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // driver: holds valid until accepted, random idle bursts between transactions
    int in_idle = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_weight(pending_weights.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (in_idle > 0)
                begin
                    in_idle <= in_idle - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_weights.size() > (in_valid && in_ready ? 0 : 0) &&
                         pending_weights.size() > 0 &&
                         !(in_valid && in_ready && pending_weights.size() == 0))
                begin
                    weight <= pending_weights[0].w;
                    last_weight <= pending_weights[0].last;
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        in_idle <= $urandom_range(1, 14);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall bursts on out_ready, checks each output transaction
    int out_stall = 0;
    always @(posedge clk)
    begin
        entry_txn_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_entries.size() == 0)
                begin
                    $display("%0t: unexpected output transaction idx=%0d", $time, entry_index);
                    errors++;
                end
                else
                begin
                    e = expected_entries.pop_front();
                    if (entry_index !== e.idx)
                    begin
                        $display("%0t: entry_index exp %0d got %0d", $time, e.idx, entry_index);
                        errors++;
                    end
                    if (probability !== e.prob)
                    begin
                        $display("%0t: probability exp %0h got %0h", $time, e.prob, probability);
                        errors++;
                    end
                    if (alias_index !== e.alias_idx)
                    begin
                        $display("%0t: alias_index exp %0d got %0d", $time, e.alias_idx,
                                 alias_index);
                        errors++;
                    end
                    if (has_alias !== e.has_alias)
                    begin
                        $display("%0t: has_alias exp %0b got %0b", $time, e.has_alias, has_alias);
                        errors++;
                    end
                    if (zero_sum_error !== e.zero_err)
                    begin
                        $display("%0t: zero_sum_error exp %0b got %0b", $time, e.zero_err,
                                 zero_sum_error);
                        errors++;
                    end
                    if (last_entry !== e.last)
                    begin
                        $display("%0t: last_entry exp %0b got %0b", $time, e.last, last_entry);
                        errors++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // run-time limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL alias_table_builder_top");
            $finish;
        end
    end

    // one well-formed set of n weights; kind picks the weight profile
    task automatic queue_set(input int n, input int kind);
        logic [31:0] w;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: w = rand_weight();
                1: w = $urandom_range(1, 1000);           // near-uniform small values
                2: w = (i == 0) ? $urandom : $urandom_range(0, 3); // one dominant entry
                default: w = 32'd0;
            endcase
            queue_weight(w, i == n - 1);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed sets
        queue_weight(32'd0, 1'b1);                    // zero sum, single weight
        queue_weight(32'd0, 1'b0);
        queue_weight(32'd0, 1'b0);
        queue_weight(32'd0, 1'b1);                    // zero sum over several
        queue_weight(32'd7, 1'b1);                    // one entry
        queue_weight(32'hFFFF_FFFF, 1'b0);
        queue_weight(32'hFFFF_FFFF, 1'b1);            // maximal equal weights
        queue_weight(32'd1, 1'b0);
        queue_weight(32'hFFFF_FFFF, 1'b1);            // extreme ratio
        queue_weight(32'd3, 1'b0);
        queue_weight(32'd3, 1'b0);
        queue_weight(32'd3, 1'b1);                    // rounding in thirds
        queue_weight(32'd0, 1'b0);
        queue_weight(32'hAAAA_5555, 1'b0);
        queue_weight(32'h5555_AAAA, 1'b1);
        // full table plus excess weights, last mark lands on an excess one
        for (int i = 0; i < MAX_N + 3; i++)
            queue_weight((i == 10 || i == MAX_N + 1) ? 32'hFFFF_FFFF : $urandom,
                         i == MAX_N + 2);

        // random sets, mostly small sizes, one medium set with a dominant entry
        for (int s = 0; s < 24; s++)
        begin
            if (s == 18)
            begin
                wait (pending_weights.size() == 0);
                calm = 1'b1;
            end
            if (s == 9)
                queue_set($urandom_range(12, 20), 2);
            else if (s % 11 == 3)
                queue_set($urandom_range(1, 4), 3);
            else
                queue_set($urandom_range(1, 4), $urandom_range(0, 2));
        end

        wait (pending_weights.size() == 0 && !in_valid);
        wait (expected_entries.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS alias_table_builder_top");
        else
            $display("FAIL alias_table_builder_top");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/atb_pkg.sv
src/atb_ram.sv
src/atb_ctrl.sv
src/atb_datapath.sv
src/alias_table_builder_top.sv
sim/tb_top.sv
